[src/vlc_pkg.sv]
// shared types and constants for the varint length codec
// no dependencies; imported by every module of the block
package vlc_pkg;

	localparam int MAX_BYTES   = 10;
	localparam int VALUE_WIDTH = 64;
	localparam int GROUP_BITS  = 7;
	localparam int CNT_W       = 4;
	localparam int SHIFT_W     = 6;

	typedef enum logic {
		CMD_ENCODE = 1'b0,
		CMD_DECODE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ENC,
		ST_DEC
	} state_t;

	typedef struct packed {
		logic        command;
		logic [63:0] value_in;
		logic [7:0]  byte_in;
	} req_t;

	typedef struct packed {
		logic [7:0]       byte_out;
		logic [63:0]      value_out;
		logic [CNT_W-1:0] byte_count;
		logic             last;
		logic             truncated;
	} rsp_t;

	// result of one pass through the group unit
	typedef struct packed {
		logic [VALUE_WIDTH-1:0] enc_rest;
		logic [GROUP_BITS-1:0]  enc_group;
		logic                   enc_more;
		logic [VALUE_WIDTH-1:0] dec_word;
	} grp_res_t;

endpackage

[src/vlc_group_unit.sv]
// shared 7-bit group unit: peels the low group off a word for encode,
// merges a group in at a bit offset for decode; uses vlc_pkg
module vlc_group_unit (
	input  logic [vlc_pkg::VALUE_WIDTH-1:0] word,
	input  logic [vlc_pkg::GROUP_BITS-1:0]  group,
	input  logic [vlc_pkg::SHIFT_W-1:0]     shift,
	output vlc_pkg::grp_res_t               res
);
	import vlc_pkg::*;

	logic [63:0]            placed;
	logic [VALUE_WIDTH-1:0] rest;

	always_comb begin
		rest           = word >> GROUP_BITS;
		res.enc_rest   = rest;
		res.enc_group  = word[GROUP_BITS-1:0];
		res.enc_more   = (rest != '0);
		// bits landing at or above the value width fall off
		placed         = {{(64-GROUP_BITS){1'b0}}, group} << shift;
		res.dec_word   = word | placed[VALUE_WIDTH-1:0];
	end

endmodule

[src/varint_length_codec.sv]
// Unsigned LEB128 varint codec, at most MAX_BYTES (10) bytes per value.
// An encode beat first captures the request and then yields one result beat
// per cycle while the result side does not stall, 1 to 10 beats, each
// through the shared group unit. A decode beat captures the byte, then merges
// it into the accumulator at offset 7 * byte index. The single output
// register frees the result side from the request side; requests are
// stalled while a run is in progress. Depends on vlc_pkg and vlc_group_unit.
module varint_length_codec (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  vlc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output vlc_pkg::rsp_t rsp
);
	import vlc_pkg::*;

	state_t                 state_q, state_d;
	logic [VALUE_WIDTH-1:0] work_q, work_d;
	logic [VALUE_WIDTH-1:0] acc_q, acc_d;
	logic [CNT_W-1:0]       idx_q, idx_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic [7:0]             byte_q, byte_d;
	logic                   out_valid_q, out_valid_d;
	rsp_t                   out_q, out_d;

	logic [VALUE_WIDTH-1:0] unit_word;
	logic [SHIFT_W-1:0]     unit_shift;
	grp_res_t               unit_res;
	logic                   slot_free;
	logic                   fin;
	logic [CNT_W-1:0]       idx_inc;
	logic                   dec_done;

	vlc_group_unit u_group (
		.word  (unit_word),
		.group (byte_q[GROUP_BITS-1:0]),
		.shift (unit_shift),
		.res   (unit_res)
	);

	assign slot_free = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_comb begin
		state_d     = state_q;
		work_d      = work_q;
		acc_d       = acc_q;
		idx_d       = idx_q;
		cnt_d       = cnt_q;
		byte_d      = byte_q;
		out_valid_d = out_valid_q && rsp_stall;
		out_d       = out_q;
		unit_word   = (state_q == ST_DEC) ? acc_q : work_q;
		unit_shift  = SHIFT_W'(GROUP_BITS * int'(idx_q));
		fin         = !unit_res.enc_more || (cnt_q == CNT_W'(MAX_BYTES));
		idx_inc     = idx_q + CNT_W'(1);
		dec_done    = !byte_q[7] || (idx_inc >= CNT_W'(MAX_BYTES));

		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req.command == CMD_DECODE) begin
						byte_d  = req.byte_in;
						state_d = ST_DEC;
					end else begin
						work_d  = req.value_in[VALUE_WIDTH-1:0];
						cnt_d   = CNT_W'(1);
						state_d = ST_ENC;
					end
				end
			end
			ST_ENC: begin
				if (slot_free) begin
					out_valid_d      = 1'b1;
					out_d.byte_out   = {unit_res.enc_more, unit_res.enc_group};
					out_d.value_out  = '0;
					out_d.byte_count = cnt_q;
					out_d.last       = fin;
					out_d.truncated  = fin && unit_res.enc_more;
					work_d           = unit_res.enc_rest;
					cnt_d            = cnt_q + CNT_W'(1);
					if (fin) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DEC: begin
				if (!dec_done) begin
					acc_d   = unit_res.dec_word;
					idx_d   = idx_inc;
					state_d = ST_IDLE;
				end else if (slot_free) begin
					// value ends here: emit and clear the accumulator
					out_valid_d      = 1'b1;
					out_d.byte_out   = '0;
					out_d.value_out  = 64'(unit_res.dec_word);
					out_d.byte_count = idx_inc;
					out_d.last       = 1'b1;
					out_d.truncated  = byte_q[7];
					acc_d            = '0;
					idx_d            = '0;
					state_d          = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			acc_q       <= acc_d;
			idx_q       <= idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		work_q <= work_d;
		cnt_q  <= cnt_d;
		byte_q <= byte_d;
		out_q  <= out_d;
	end

endmodule

[src/vlc_checker.sv]
// port-level checks for the varint length codec, bound to the top level
// depends on vlc_pkg
module vlc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input vlc_pkg::rsp_t rsp
);
	import vlc_pkg::*;

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.truncated |-> rsp.last)
		else $error("truncated set on a non-final result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.byte_count != '0 && rsp.byte_count <= CNT_W'(MAX_BYTES))
		else $error("byte count out of range");

	// a non-final encode byte always carries its continue bit
	a_cont_bit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> rsp.byte_out[7] && rsp.value_out == '0)
		else $error("non-final encode byte malformed");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.byte_out == '0 || rsp.value_out == '0)
		else $error("result carries both a byte and a value");

endmodule

bind varint_length_codec vlc_checker u_vlc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
